[hdl/wfhp_pkg.sv]
// Shared types and constants for the wave file header parser.
`timescale 1ns / 1ps
`default_nettype none
package wfhp_pkg;

	typedef enum logic [1:0] {
		KIND_DATA   = 2'd0,
		KIND_REPORT = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [1:0]  channel_count;
		logic [4:0]  sample_bits;
		logic [31:0] rate_hz;
		logic [2:0]  error_code;
		logic        last;
	} result_t;

	// One queue entry holds everything a single input byte produced.
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} entry_t;

endpackage
`default_nettype wire

[hdl/wfhp_front.sv]
// Byte parser: walks the RIFF chunk structure and builds result entries.
`timescale 1ns / 1ps
`default_nettype none
module wfhp_front
	import wfhp_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] file_byte,
	input  wire logic       end_of_file,
	input  wire logic       q_full,
	output logic            q_push,
	output entry_t          q_entry
);

	localparam logic [31:0] RIFF_ID  = 32'h4646_4952;
	localparam logic [31:0] FMT_ID   = 32'h2074_6D66;
	localparam logic [31:0] DATA_ID  = 32'h6174_6164;
	localparam logic [31:0] WAVE_TAG = 32'h5741_5645;

	localparam logic [2:0] ERR_NO_RIFF   = 3'd0;
	localparam logic [2:0] ERR_NO_WAVE   = 3'd1;
	localparam logic [2:0] ERR_NO_FMT    = 3'd2;
	localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
	localparam logic [2:0] ERR_CHANNELS  = 3'd4;
	localparam logic [2:0] ERR_BITS      = 3'd5;
	localparam logic [2:0] ERR_NO_DATA   = 3'd6;
	localparam logic [2:0] ERR_TRUNCATED = 3'd7;

	typedef enum logic [15:0] {
		PH_RIFF_ID   = 16'h0001,
		PH_RIFF_SIZE = 16'h0002,
		PH_WAVE      = 16'h0004,
		PH_SUB_ID    = 16'h0008,
		PH_SIZE_FMT  = 16'h0010,
		PH_SIZE_DATA = 16'h0020,
		PH_SIZE_OTH  = 16'h0040,
		PH_FMT_TAG   = 16'h0080,
		PH_FMT_CH    = 16'h0100,
		PH_FMT_RATE  = 16'h0200,
		PH_FMT_BRATE = 16'h0400,
		PH_FMT_ALIGN = 16'h0800,
		PH_FMT_BITS  = 16'h1000,
		PH_SKIP      = 16'h2000,
		PH_DATA      = 16'h4000,
		PH_DONE      = 16'h8000
	} phase_t;

	function automatic result_t mk_data(input logic [7:0] b, input logic lst);
		result_t r;
		r = '0;
		r.kind = KIND_DATA;
		r.data_byte = b;
		r.last = lst;
		return r;
	endfunction

	function automatic result_t mk_err(input logic [2:0] code);
		result_t r;
		r = '0;
		r.kind = KIND_ERROR;
		r.error_code = code;
		r.last = 1'b1;
		return r;
	endfunction

	phase_t      phase_q, phase_n;
	logic [31:0] shift_q, shift_n;
	logic [2:0]  idx_q, idx_n;
	logic [31:0] chunk_q, chunk_n;
	logic [31:0] riff_q, riff_n;
	logic        swapped_q, swapped_n;
	logic        fmt_seen_q, fmt_seen_n;
	logic [1:0]  chan_q, chan_n;
	logic [4:0]  bits_q, bits_n;
	logic [31:0] rate_q, rate_n;
	logic [7:0]  held_q, held_n;

	logic [31:0] sh;
	logic [31:0] sh_rev;
	logic [31:0] v32;
	logic [15:0] v16;
	logic [2:0]  idx_inc;
	logic        done2, done4;
	logic [31:0] riff_dec;
	logic [31:0] chunk_dec;
	logic        accept;
	logic        bnd, fail_en, fail_nf;
	logic [2:0]  fail_code;
	logic [1:0]  n_res;
	result_t     r0, r1;

	assign sh       = {shift_q[23:0], file_byte};
	assign sh_rev   = {sh[7:0], sh[15:8], sh[23:16], sh[31:24]};
	assign v32      = swapped_q ? sh : sh_rev;
	assign v16      = swapped_q ? sh[15:0] : {sh[7:0], sh[15:8]};
	assign idx_inc  = idx_q + 3'd1;
	assign done2    = idx_inc >= 3'd2;
	assign done4    = idx_inc >= 3'd4;
	assign riff_dec = (riff_q != 32'd0) ? riff_q - 32'd1 : riff_q;
	assign chunk_dec = chunk_q - 32'd1;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		phase_n    = phase_q;
		shift_n    = shift_q;
		idx_n      = idx_q;
		chunk_n    = chunk_q;
		riff_n     = riff_q;
		swapped_n  = swapped_q;
		fmt_seen_n = fmt_seen_q;
		chan_n     = chan_q;
		bits_n     = bits_q;
		rate_n     = rate_q;
		held_n     = held_q;
		bnd        = 1'b0;
		fail_en    = 1'b0;
		fail_nf    = 1'b0;
		fail_code  = ERR_NO_RIFF;
		n_res      = 2'd0;
		r0         = '0;
		r1         = '0;

		unique case (phase_q) inside
			PH_RIFF_ID: begin
				shift_n = sh;
				idx_n   = done4 ? 3'd0 : idx_inc;
				if (done4) begin
					if (sh_rev == RIFF_ID) begin
						swapped_n = 1'b0;
						phase_n   = PH_RIFF_SIZE;
					end else if (sh == RIFF_ID) begin
						swapped_n = 1'b1;
						phase_n   = PH_RIFF_SIZE;
					end else begin
						fail_en   = 1'b1;
						fail_code = ERR_NO_RIFF;
					end
				end
			end
			PH_RIFF_SIZE: begin
				shift_n = sh;
				idx_n   = done4 ? 3'd0 : idx_inc;
				if (done4) begin
					riff_n  = v32;
					phase_n = PH_WAVE;
				end
			end
			PH_WAVE: begin
				riff_n  = riff_dec;
				shift_n = sh;
				idx_n   = done4 ? 3'd0 : idx_inc;
				if (done4) begin
					if (sh != WAVE_TAG) begin
						fail_en   = 1'b1;
						fail_code = ERR_NO_WAVE;
					end else begin
						bnd = 1'b1;
					end
				end
			end
			PH_SUB_ID: begin
				riff_n  = riff_dec;
				shift_n = sh;
				idx_n   = done4 ? 3'd0 : idx_inc;
				if (riff_dec == 32'd0) begin
					fail_en = 1'b1;
					fail_nf = 1'b1;
				end else if (done4) begin
					if (v32 == FMT_ID && !fmt_seen_q) begin
						phase_n = PH_SIZE_FMT;
					end else if (v32 == DATA_ID) begin
						if (fmt_seen_q) begin
							phase_n = PH_SIZE_DATA;
						end else begin
							fail_en   = 1'b1;
							fail_code = ERR_NO_FMT;
						end
					end else begin
						phase_n = PH_SIZE_OTH;
					end
				end
			end
			PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_OTH: begin
				riff_n  = riff_dec;
				shift_n = sh;
				idx_n   = done4 ? 3'd0 : idx_inc;
				if (!done4) begin
					if (riff_dec == 32'd0) begin
						fail_en = 1'b1;
						fail_nf = 1'b1;
					end
				end else begin
					chunk_n = v32;
					if (phase_q == PH_SIZE_FMT) begin
						if (v32 < 32'd16) begin
							fail_en   = 1'b1;
							fail_code = ERR_NO_FMT;
						end else begin
							phase_n = PH_FMT_TAG;
						end
					end else if (phase_q == PH_SIZE_DATA) begin
						n_res            = 2'd1;
						r0.kind          = KIND_REPORT;
						r0.channel_count = chan_q;
						r0.sample_bits   = bits_q;
						r0.rate_hz       = rate_q;
						phase_n = (v32 == 32'd0) ? PH_DONE : PH_DATA;
					end else if (v32 > riff_dec) begin
						fail_en = 1'b1;
						fail_nf = 1'b1;
					end else if (v32 == 32'd0) begin
						bnd = 1'b1;
					end else begin
						phase_n = PH_SKIP;
					end
				end
			end
			PH_FMT_TAG, PH_FMT_CH, PH_FMT_ALIGN, PH_FMT_BITS: begin
				riff_n  = riff_dec;
				chunk_n = chunk_dec;
				shift_n = sh;
				idx_n   = done2 ? 3'd0 : idx_inc;
				if (done2) begin
					if (phase_q == PH_FMT_TAG) begin
						if (v16 != 16'd1) begin
							fail_en   = 1'b1;
							fail_code = ERR_NOT_PCM;
						end else begin
							phase_n = PH_FMT_CH;
						end
					end else if (phase_q == PH_FMT_CH) begin
						chan_n = v16[1:0];
						if (v16 != 16'd1 && v16 != 16'd2) begin
							fail_en   = 1'b1;
							fail_code = ERR_CHANNELS;
						end else begin
							phase_n = PH_FMT_RATE;
						end
					end else if (phase_q == PH_FMT_ALIGN) begin
						phase_n = PH_FMT_BITS;
					end else begin
						bits_n = v16[4:0];
						if (v16 != 16'd8 && v16 != 16'd16) begin
							fail_en   = 1'b1;
							fail_code = ERR_BITS;
						end else begin
							fmt_seen_n = 1'b1;
							if (chunk_dec == 32'd0) begin
								bnd = 1'b1;
							end else begin
								phase_n = PH_SKIP;
							end
						end
					end
				end
			end
			PH_FMT_RATE, PH_FMT_BRATE: begin
				riff_n  = riff_dec;
				chunk_n = chunk_dec;
				shift_n = sh;
				idx_n   = done4 ? 3'd0 : idx_inc;
				if (done4) begin
					if (phase_q == PH_FMT_RATE) begin
						rate_n  = v32;
						phase_n = PH_FMT_BRATE;
					end else begin
						phase_n = PH_FMT_ALIGN;
					end
				end
			end
			PH_SKIP: begin
				riff_n  = riff_dec;
				chunk_n = chunk_dec;
				if (chunk_dec == 32'd0) begin
					bnd = 1'b1;
				end
			end
			PH_DATA: begin
				chunk_n = chunk_dec;
				// A swapped 16-bit stream holds the first byte of each pair and
				// sends the pair reversed once the second byte arrives.
				if (swapped_q && bits_q == 5'd16) begin
					if (idx_q == 3'd0) begin
						if (chunk_dec == 32'd0) begin
							n_res = 2'd1;
							r0    = mk_data(file_byte, 1'b1);
						end else begin
							held_n = file_byte;
							idx_n  = 3'd1;
						end
					end else begin
						n_res = 2'd2;
						r0    = mk_data(file_byte, 1'b0);
						r1    = mk_data(held_q, chunk_dec == 32'd0);
						idx_n = 3'd0;
					end
				end else begin
					n_res = 2'd1;
					r0    = mk_data(file_byte, chunk_dec == 32'd0);
				end
				if (chunk_dec == 32'd0) begin
					phase_n = PH_DONE;
				end
			end
			default: begin
			end
		endcase

		// A chunk boundary with nothing left of the RIFF body ends the walk.
		if (bnd) begin
			phase_n = PH_SUB_ID;
			idx_n   = 3'd0;
			if (riff_n == 32'd0) begin
				fail_en = 1'b1;
				fail_nf = 1'b1;
			end
		end

		if (fail_en) begin
			n_res   = 2'd1;
			r0      = mk_err(fail_nf ? (fmt_seen_n ? ERR_NO_DATA : ERR_NO_FMT) : fail_code);
			r1      = '0;
			phase_n = PH_DONE;
		end

		if (end_of_file) begin
			if (!fail_en && phase_n != PH_DONE) begin
				n_res = 2'd1;
				r0    = mk_err(ERR_TRUNCATED);
				r1    = '0;
			end
			phase_n    = PH_RIFF_ID;
			shift_n    = '0;
			idx_n      = '0;
			chunk_n    = '0;
			riff_n     = '0;
			swapped_n  = 1'b0;
			fmt_seen_n = 1'b0;
			chan_n     = '0;
			bits_n     = '0;
			rate_n     = '0;
			held_n     = '0;
		end
	end

	assign q_push      = accept && (n_res != 2'd0);
	assign q_entry.two = (n_res == 2'd2);
	assign q_entry.r0  = r0;
	assign q_entry.r1  = r1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_RIFF_ID;
			shift_q    <= '0;
			idx_q      <= '0;
			chunk_q    <= '0;
			riff_q     <= '0;
			swapped_q  <= 1'b0;
			fmt_seen_q <= 1'b0;
			chan_q     <= '0;
			bits_q     <= '0;
			rate_q     <= '0;
			held_q     <= '0;
		end else if (accept) begin
			phase_q    <= phase_n;
			shift_q    <= shift_n;
			idx_q      <= idx_n;
			chunk_q    <= chunk_n;
			riff_q     <= riff_n;
			swapped_q  <= swapped_n;
			fmt_seen_q <= fmt_seen_n;
			chan_q     <= chan_n;
			bits_q     <= bits_n;
			rate_q     <= rate_n;
			held_q     <= held_n;
		end
	end

endmodule
`default_nettype wire

[hdl/wfhp_queue.sv]
// Small queue of result entries between the parser and the output side.
`timescale 1ns / 1ps
`default_nettype none
module wfhp_queue
	import wfhp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push,
	input  entry_t      push_entry,
	output logic        full,
	input  wire logic   pop,
	output logic        not_empty,
	output entry_t      head
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	entry_t          mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/wfhp_back.sv]
// Output side: sends the one or two results of each queue entry as beats.
`timescale 1ns / 1ps
`default_nettype none
module wfhp_back
	import wfhp_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   head_valid,
	input  entry_t      head,
	output logic        pop,
	output logic        out_valid,
	input  wire logic   out_stall,
	output result_t     out_res
);

	logic sel_q;
	logic beat;

	assign out_valid = head_valid;
	assign out_res   = sel_q ? head.r1 : head.r0;
	assign beat      = head_valid && !out_stall;
	// The entry leaves the queue with its final beat.
	assign pop       = beat && (sel_q || !head.two);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q <= 1'b0;
		end else if (beat) begin
			sel_q <= head.two && !sel_q;
		end
	end

endmodule
`default_nettype wire

[hdl/wave_file_header_parser.sv]
// Top level of the wave file header parser.
`timescale 1ns / 1ps
`default_nettype none
// Takes a RIFF/WAVE file one byte per beat and returns a format report when the
// data chunk starts, then the sample bytes in little-endian order, or a single
// error beat with last set. While the queue is not full the parser accepts one
// byte every cycle; each byte is handled in the cycle it is accepted, and its
// results (none, one or two) wait in a queue of QUEUE_DEPTH entries (2 or more)
// until the output side takes them, one result per unstalled cycle. A byte that
// yields two results, as in byte-swapped 16-bit streams, is sent as two beats, so
// input stalls only when the queue fills behind a slow or stalled output. A byte
// flagged end_of_file returns the parser to its reset state for the next file.
module wave_file_header_parser
	import wfhp_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  file_byte,
	input  wire logic        end_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic [1:0]       channel_count,
	output logic [4:0]       sample_bits,
	output logic [31:0]      rate_hz,
	output logic [2:0]       error_code,
	output logic             last
);

	logic    q_full;
	logic    q_push;
	entry_t  q_entry;
	logic    q_pop;
	logic    q_not_empty;
	entry_t  q_head;
	result_t res;

	wfhp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.file_byte   (file_byte),
		.end_of_file (end_of_file),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_entry     (q_entry)
	);

	wfhp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_entry),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	wfhp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_not_empty),
		.head       (q_head),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_res    (res)
	);

	assign kind          = res.kind;
	assign data_byte     = res.data_byte;
	assign channel_count = res.channel_count;
	assign sample_bits   = res.sample_bits;
	assign rate_hz       = res.rate_hz;
	assign error_code    = res.error_code;
	assign last          = res.last;

endmodule
`default_nettype wire

[sim/wave_parse_checker.sv]
// Chunk ids shared by the stimulus and the checker, plus the checker that predicts and compares.
`timescale 1ns / 1ps
package wfhp_tb_pkg;

	localparam logic [31:0] RIFF_ID  = 32'h4646_4952;
	localparam logic [31:0] FMT_ID   = 32'h2074_6D66;
	localparam logic [31:0] DATA_ID  = 32'h6174_6164;
	// The WAVE tag is compared in file order, whatever the byte order of the file.
	localparam logic [31:0] WAVE_TAG = 32'h5741_5645;

endpackage

module wave_parse_checker
	import wfhp_pkg::*;
	import wfhp_tb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  file_byte,
	input  wire logic        end_of_file,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  data_byte,
	input  wire logic [1:0]  channel_count,
	input  wire logic [4:0]  sample_bits,
	input  wire logic [31:0] rate_hz,
	input  wire logic [2:0]  error_code,
	input  wire logic        last,
	output int               mismatch_count,
	output int               results_pending,
	output int               results_checked
);

	localparam logic [2:0] CODE_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_RIFF   = 3'd0;
	localparam logic [2:0] ERR_NO_WAVE   = 3'd1;
	localparam logic [2:0] ERR_NO_FMT    = 3'd2;
	localparam logic [2:0] ERR_NOT_PCM   = 3'd3;
	localparam logic [2:0] ERR_CHANNELS  = 3'd4;
	localparam logic [2:0] ERR_BITS      = 3'd5;
	localparam logic [2:0] ERR_NO_DATA   = 3'd6;
	localparam logic [2:0] ERR_TRUNCATED = 3'd7;

	typedef enum logic [3:0] {
		AT_RIFF_ID, AT_RIFF_SIZE, AT_WAVE_TAG, AT_CHUNK_ID, AT_FMT_SIZE, AT_DATA_SIZE,
		AT_OTHER_SIZE, AT_FMT_TAG, AT_FMT_CHANS, AT_FMT_RATE, AT_FMT_BYTE_RATE,
		AT_FMT_ALIGN, AT_FMT_BITS, AT_SKIP, AT_SAMPLES, AT_IDLE
	} phase_t;

	phase_t      phase;
	logic [31:0] shift;
	logic [2:0]  byte_idx;
	logic [31:0] chunk_left;
	logic [31:0] riff_left;
	logic        swapped;
	logic        have_fmt;
	logic [15:0] chans_saved;
	logic [15:0] bits_saved;
	logic [31:0] rate_saved;
	logic [7:0]  held;

	// Results made by the byte being predicted; an error replaces them.
	result_t step_res [2];
	int      step_n;
	logic    step_err;

	result_t expected_results [$];

	function automatic void reset_parser();
		phase = AT_RIFF_ID;
		shift = '0;
		byte_idx = '0;
		chunk_left = '0;
		riff_left = '0;
		swapped = 1'b0;
		have_fmt = 1'b0;
		chans_saved = '0;
		bits_saved = '0;
		rate_saved = '0;
		held = '0;
	endfunction

	function automatic logic [31:0] field32();
		return swapped ? shift : {shift[7:0], shift[15:8], shift[23:16], shift[31:24]};
	endfunction

	function automatic logic [15:0] field16();
		return swapped ? shift[15:0] : {shift[7:0], shift[15:8]};
	endfunction

	function automatic logic take_byte(logic [7:0] b, int len);
		shift = {shift[23:0], b};
		byte_idx = byte_idx + 3'd1;
		if (byte_idx >= len) begin
			byte_idx = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void add_result(kind_t k, logic [7:0] d, logic [1:0] ch, logic [4:0] bits,
			logic [31:0] rate, logic [2:0] code, logic lst);
		if (step_n >= 2)
			return;
		step_res[step_n].kind = k;
		step_res[step_n].data_byte = d;
		step_res[step_n].channel_count = ch;
		step_res[step_n].sample_bits = bits;
		step_res[step_n].rate_hz = rate;
		step_res[step_n].error_code = code;
		step_res[step_n].last = lst;
		step_n++;
	endfunction

	function automatic void raise_error(logic [2:0] code);
		step_n = 0;
		add_result(KIND_ERROR, 8'h00, 2'd0, 5'd0, 32'd0, code, 1'b1);
		step_err = 1'b1;
		phase = AT_IDLE;
	endfunction

	function automatic void raise_missing();
		raise_error(have_fmt ? ERR_NO_DATA : ERR_NO_FMT);
	endfunction

	function automatic void chunk_boundary();
		phase = AT_CHUNK_ID;
		byte_idx = '0;
		if (riff_left == 0)
			raise_missing();
	endfunction

	function automatic void riff_count_down();
		if (riff_left != 0)
			riff_left = riff_left - 1;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic eof);
		logic        got;
		logic [31:0] word;
		step_n = 0;
		step_err = 1'b0;
		case (phase)
			AT_RIFF_ID: begin
				if (take_byte(b, 4)) begin
					if (field32() == RIFF_ID && !swapped) begin
						phase = AT_RIFF_SIZE;
					end else if (shift == RIFF_ID) begin
						swapped = 1'b1;
						phase = AT_RIFF_SIZE;
					end else begin
						raise_error(ERR_NO_RIFF);
					end
				end
			end
			AT_RIFF_SIZE: begin
				if (take_byte(b, 4)) begin
					riff_left = field32();
					phase = AT_WAVE_TAG;
				end
			end
			AT_WAVE_TAG: begin
				riff_count_down();
				if (take_byte(b, 4)) begin
					if (shift != WAVE_TAG)
						raise_error(ERR_NO_WAVE);
					else
						chunk_boundary();
				end
			end
			AT_CHUNK_ID: begin
				riff_count_down();
				got = take_byte(b, 4);
				if (riff_left == 0) begin
					raise_missing();
				end else if (got) begin
					word = field32();
					if (word == FMT_ID && !have_fmt) begin
						phase = AT_FMT_SIZE;
					end else if (word == DATA_ID) begin
						if (have_fmt)
							phase = AT_DATA_SIZE;
						else
							raise_error(ERR_NO_FMT);
					end else begin
						phase = AT_OTHER_SIZE;
					end
				end
			end
			AT_FMT_SIZE, AT_DATA_SIZE, AT_OTHER_SIZE: begin
				riff_count_down();
				if (!take_byte(b, 4)) begin
					if (riff_left == 0)
						raise_missing();
				end else begin
					word = field32();
					chunk_left = word;
					if (phase == AT_FMT_SIZE) begin
						if (word < 16)
							raise_error(ERR_NO_FMT);
						else
							phase = AT_FMT_TAG;
					end else if (phase == AT_DATA_SIZE) begin
						add_result(KIND_REPORT, 8'h00, chans_saved[1:0], bits_saved[4:0],
							rate_saved, CODE_NONE, 1'b0);
						phase = (word == 0) ? AT_IDLE : AT_SAMPLES;
					end else if (word > riff_left) begin
						raise_missing();
					end else if (word == 0) begin
						chunk_boundary();
					end else begin
						phase = AT_SKIP;
					end
				end
			end
			AT_FMT_TAG, AT_FMT_CHANS, AT_FMT_ALIGN, AT_FMT_BITS: begin
				riff_count_down();
				chunk_left = chunk_left - 1;
				if (take_byte(b, 2)) begin
					word = {16'h0000, field16()};
					case (phase)
						AT_FMT_TAG: begin
							if (word != 1)
								raise_error(ERR_NOT_PCM);
							else
								phase = AT_FMT_CHANS;
						end
						AT_FMT_CHANS: begin
							chans_saved = word[15:0];
							if (word != 1 && word != 2)
								raise_error(ERR_CHANNELS);
							else
								phase = AT_FMT_RATE;
						end
						AT_FMT_ALIGN: phase = AT_FMT_BITS;
						default: begin
							bits_saved = word[15:0];
							if (word != 8 && word != 16) begin
								raise_error(ERR_BITS);
							end else begin
								have_fmt = 1'b1;
								if (chunk_left == 0)
									chunk_boundary();
								else
									phase = AT_SKIP;
							end
						end
					endcase
				end
			end
			AT_FMT_RATE, AT_FMT_BYTE_RATE: begin
				riff_count_down();
				chunk_left = chunk_left - 1;
				if (take_byte(b, 4)) begin
					if (phase == AT_FMT_RATE) begin
						rate_saved = field32();
						phase = AT_FMT_BYTE_RATE;
					end else begin
						phase = AT_FMT_ALIGN;
					end
				end
			end
			AT_SKIP: begin
				riff_count_down();
				chunk_left = chunk_left - 1;
				if (chunk_left == 0)
					chunk_boundary();
			end
			AT_SAMPLES: begin
				chunk_left = chunk_left - 1;
				// Swapped 16-bit samples: hold the first byte of a pair, send both on the second.
				if (swapped && bits_saved == 16) begin
					if (byte_idx == 0) begin
						if (chunk_left == 0) begin
							add_result(KIND_DATA, b, 2'd0, 5'd0, 32'd0, CODE_NONE, 1'b1);
						end else begin
							held = b;
							byte_idx = 3'd1;
						end
					end else begin
						add_result(KIND_DATA, b, 2'd0, 5'd0, 32'd0, CODE_NONE, 1'b0);
						add_result(KIND_DATA, held, 2'd0, 5'd0, 32'd0, CODE_NONE,
							chunk_left == 0);
						byte_idx = '0;
					end
				end else begin
					add_result(KIND_DATA, b, 2'd0, 5'd0, 32'd0, CODE_NONE, chunk_left == 0);
				end
				if (chunk_left == 0)
					phase = AT_IDLE;
			end
			default: ;
		endcase
		if (eof) begin
			if (!step_err && phase != AT_IDLE)
				raise_error(ERR_TRUNCATED);
			reset_parser();
		end
		for (int i = 0; i < step_n; i++)
			expected_results.push_back(step_res[i]);
	endfunction

	task automatic report_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch on result %0d: %s", $time, results_checked, msg);
	endtask

	task automatic compare_result(result_t seen);
		result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch($sformatf("unexpected beat, kind %0d data %h code %0d",
				seen.kind, seen.data_byte, seen.error_code));
			return;
		end
		want = expected_results.pop_front();
		if (seen.kind != want.kind)
			report_mismatch($sformatf("kind %0d, want %0d", seen.kind, want.kind));
		if (seen.data_byte != want.data_byte)
			report_mismatch($sformatf("data_byte %h, want %h", seen.data_byte, want.data_byte));
		if (seen.channel_count != want.channel_count)
			report_mismatch($sformatf("channel_count %0d, want %0d",
				seen.channel_count, want.channel_count));
		if (seen.sample_bits != want.sample_bits)
			report_mismatch($sformatf("sample_bits %0d, want %0d",
				seen.sample_bits, want.sample_bits));
		if (seen.rate_hz != want.rate_hz)
			report_mismatch($sformatf("rate_hz %h, want %h", seen.rate_hz, want.rate_hz));
		if (seen.error_code != want.error_code)
			report_mismatch($sformatf("error_code %0d, want %0d",
				seen.error_code, want.error_code));
		if (seen.last != want.last)
			report_mismatch($sformatf("last %0d, want %0d", seen.last, want.last));
		results_checked++;
	endtask

	initial begin
		mismatch_count = 0;
		results_pending = 0;
		results_checked = 0;
		reset_parser();
	end

	always @(posedge clk) begin : watch
		result_t seen;
		if (arst_n) begin
			// The input byte goes first so that a result it makes at once finds its prediction.
			if (in_valid && !in_stall)
				predict_byte(file_byte, end_of_file);
			if (out_valid && !out_stall) begin
				seen.kind = kind_t'(kind);
				seen.data_byte = data_byte;
				seen.channel_count = channel_count;
				seen.sample_bits = sample_bits;
				seen.rate_hz = rate_hz;
				seen.error_code = error_code;
				seen.last = last;
				compare_result(seen);
			end
			results_pending = expected_results.size();
		end
	end

endmodule

[sim/wave_file_header_parser_tb.sv]
// Testbench top for the wave file header parser: builds wave files and drives them byte by byte.
`timescale 1ns / 1ps
module wave_file_header_parser_tb;
	import wfhp_pkg::*;
	import wfhp_tb_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	// Byte budget for the whole run, directed files included.
	localparam int TOTAL_BYTES = 850;

	typedef struct {
		logic        swapped;
		logic [15:0] tag;
		logic [15:0] chans;
		logic [15:0] bits;
		logic [31:0] rate;
		int          fmt_size;
		int          junk_before;
		int          junk_after;
		int          junk_len;
		logic        second_fmt;
		logic        data_first;
		int          data_len;
		logic        riff_exact;
		logic [31:0] riff_size;
	} wave_opts_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  file_byte = 8'h00;
	logic        end_of_file = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [1:0]  channel_count;
	logic [4:0]  sample_bits;
	logic [31:0] rate_hz;
	logic [2:0]  error_code;
	logic        last;

	int mismatch_count;
	int results_pending;
	int results_checked;
	int cycle_count = 0;
	int stall_hold = 0;
	int files_sent = 0;
	int bytes_sent = 0;
	logic no_gaps = 1'b0;
	logic file_swapped = 1'b0;
	logic [7:0] file_q [$];

	wave_file_header_parser uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.file_byte(file_byte), .end_of_file(end_of_file),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .data_byte(data_byte), .channel_count(channel_count),
		.sample_bits(sample_bits), .rate_hz(rate_hz), .error_code(error_code), .last(last)
	);

	wave_parse_checker parse_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.file_byte(file_byte), .end_of_file(end_of_file),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .data_byte(data_byte), .channel_count(channel_count),
		.sample_bits(sample_bits), .rate_hz(rate_hz), .error_code(error_code), .last(last),
		.mismatch_count(mismatch_count), .results_pending(results_pending),
		.results_checked(results_checked)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run stopped at the cycle limit with %0d results outstanding.",
				results_pending);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Output side stalls: mostly short, some long, with calm stretches in between.
	always @(posedge clk) begin : out_side
		int r;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(20, 100);
			end else if (r < 60) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 3);
			end else if (r < 92) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(3, 40);
			end
		end
	end

	function automatic void put8(logic [7:0] b);
		file_q.push_back(b);
	endfunction

	function automatic void put16(logic [15:0] v);
		if (file_swapped) begin
			put8(v[15:8]);
			put8(v[7:0]);
		end else begin
			put8(v[7:0]);
			put8(v[15:8]);
		end
	endfunction

	function automatic void put32(logic [31:0] v);
		if (file_swapped) begin
			put16(v[31:16]);
			put16(v[15:0]);
		end else begin
			put16(v[15:0]);
			put16(v[31:16]);
		end
	endfunction

	function automatic void put_junk(int len);
		logic [31:0] id;
		int n;
		id = $urandom;
		if (id == FMT_ID || id == DATA_ID)
			id = id ^ 32'h1;
		n = (len < 0) ? $urandom_range(0, 6) : len;
		put32(id);
		put32(n);
		// An oversized chunk is rejected at its size, so its body is only hinted at.
		repeat ((n <= 16) ? n : 4) put8(8'($urandom));
	endfunction

	function automatic void put_samples(int len);
		put32(DATA_ID);
		put32(len);
		repeat (len) put8(8'($urandom));
	endfunction

	function automatic void build_file(wave_opts_t o);
		logic [31:0] size_val;
		file_q.delete();
		file_swapped = o.swapped;
		put32(RIFF_ID);
		put32(32'h0);
		put8(WAVE_TAG[31:24]);
		put8(WAVE_TAG[23:16]);
		put8(WAVE_TAG[15:8]);
		put8(WAVE_TAG[7:0]);
		if (o.data_first)
			put_samples(o.data_len);
		repeat (o.junk_before) put_junk(o.junk_len);
		put32(FMT_ID);
		put32(o.fmt_size);
		if (o.fmt_size >= 16) begin
			put16(o.tag);
			put16(o.chans);
			put32(o.rate);
			put32(o.rate * o.chans * o.bits / 8);
			put16(o.chans * o.bits / 8);
			put16(o.bits);
			repeat (o.fmt_size - 16) put8(8'($urandom));
		end else begin
			repeat (o.fmt_size) put8(8'($urandom));
		end
		if (o.second_fmt) begin
			put32(FMT_ID);
			put32(32'd16);
			repeat (16) put8(8'($urandom));
		end
		repeat (o.junk_after) put_junk(o.junk_len);
		if (!o.data_first)
			put_samples(o.data_len);
		size_val = o.riff_exact ? 32'(file_q.size() - 8) : o.riff_size;
		for (int i = 0; i < 4; i++)
			file_q[file_swapped ? 7 - i : 4 + i] = size_val[8 * i +: 8];
	endfunction

	function automatic wave_opts_t plain_opts();
		wave_opts_t o;
		o.swapped = 1'b0;
		o.tag = 16'd1;
		o.chans = 16'd1;
		o.bits = 16'd8;
		o.rate = 32'd44100;
		o.fmt_size = 16;
		o.junk_before = 0;
		o.junk_after = 0;
		o.junk_len = -1;
		o.second_fmt = 1'b0;
		o.data_first = 1'b0;
		o.data_len = 4;
		o.riff_exact = 1'b1;
		o.riff_size = 32'd0;
		return o;
	endfunction

	function automatic wave_opts_t random_opts();
		wave_opts_t o;
		o = plain_opts();
		o.swapped = 1'($urandom_range(0, 1));
		o.chans = 16'($urandom_range(1, 2));
		o.bits = $urandom_range(0, 1) ? 16'd16 : 16'd8;
		case ($urandom_range(0, 9))
			0: o.rate = '0;
			1: o.rate = '1;
			default: o.rate = $urandom;
		endcase
		o.fmt_size = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : 16;
		o.junk_before = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
		o.junk_after = int'($urandom_range(0, 4) == 0);
		o.second_fmt = ($urandom_range(0, 9) == 0);
		o.data_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
		return o;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	// Called at a rising edge; returns at the edge where the beat is taken.
	task automatic send_byte(logic [7:0] b, logic eof);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		file_byte <= b;
		end_of_file <= eof;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_file();
		no_gaps = ($urandom_range(0, 3) == 0);
		foreach (file_q[i])
			send_byte(file_q[i], i == file_q.size() - 1);
		files_sent++;
		bytes_sent += file_q.size();
	endtask

	initial begin : stimulus
		wave_opts_t o;
		int pick;
		int lim;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Normal mono 8-bit file with a zero rate.
		o = plain_opts();
		o.rate = '0;
		o.data_len = 5;
		build_file(o);
		send_file();
		// Swapped stereo 16-bit, odd length so the last byte stands alone, top rate.
		o = plain_opts();
		o.swapped = 1'b1;
		o.chans = 16'd2;
		o.bits = 16'd16;
		o.rate = '1;
		o.data_len = 7;
		build_file(o);
		send_file();
		o.data_len = 6;
		build_file(o);
		send_file();
		// Long fmt, unknown chunks and a second fmt chunk that must be skipped.
		o = plain_opts();
		o.chans = 16'd2;
		o.bits = 16'd16;
		o.fmt_size = 18;
		o.junk_before = 1;
		o.junk_after = 1;
		o.second_fmt = 1'b1;
		build_file(o);
		send_file();
		// Neither byte order of RIFF.
		o = plain_opts();
		build_file(o);
		file_q[3] = 8'h58;
		send_file();
		// Broken WAVE tag in a swapped file.
		o.swapped = 1'b1;
		build_file(o);
		file_q[10] = 8'h00;
		send_file();
		// Data chunk ahead of fmt.
		o = plain_opts();
		o.data_first = 1'b1;
		build_file(o);
		send_file();
		o = plain_opts();
		o.tag = 16'd3;
		build_file(o);
		send_file();
		o = plain_opts();
		o.chans = 16'd3;
		build_file(o);
		send_file();
		o = plain_opts();
		o.bits = 16'd24;
		build_file(o);
		send_file();
		o = plain_opts();
		o.fmt_size = 14;
		build_file(o);
		send_file();
		// Empty data chunk followed by bytes that must be ignored.
		o = plain_opts();
		o.data_len = 0;
		build_file(o);
		repeat (3) put8(8'hFF);
		send_file();
		// File ends in the middle of the samples.
		o = plain_opts();
		o.data_len = 10;
		build_file(o);
		repeat (4) void'(file_q.pop_back());
		send_file();
		// RIFF body runs out before fmt, and right after fmt.
		o = plain_opts();
		o.riff_exact = 1'b0;
		o.riff_size = 32'd4;
		build_file(o);
		send_file();
		o.riff_size = 32'd28;
		build_file(o);
		send_file();
		// Unknown chunk larger than what is left of the RIFF body.
		o = plain_opts();
		o.junk_before = 1;
		o.junk_len = 200;
		build_file(o);
		send_file();
		// A one-byte file.
		file_q.delete();
		put8(8'h52);
		send_file();

		while (bytes_sent < TOTAL_BYTES) begin
			o = random_opts();
			pick = $urandom_range(0, 99);
			if (pick >= 80 && pick < 88) begin
				o.riff_exact = 1'b0;
				o.riff_size = $urandom_range(0, 60);
			end else if (pick >= 88 && pick < 94) begin
				case ($urandom_range(0, 4))
					0: o.tag = 16'($urandom_range(0, 3));
					1: o.chans = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
					2: o.bits = ($urandom_range(0, 1) == 0) ? 16'($urandom) : 16'($urandom_range(0, 24));
					3: o.data_first = 1'b1;
					default: o.fmt_size = $urandom_range(0, 15);
				endcase
			end
			build_file(o);
			lim = (file_q.size() < 44) ? file_q.size() : 44;
			if (pick >= 55 && pick < 65) begin
				repeat ($urandom_range(1, file_q.size() - 1)) void'(file_q.pop_back());
			end else if (pick >= 65 && pick < 75) begin
				file_q[$urandom_range(0, lim - 1)] = 8'($urandom);
			end else if (pick >= 75 && pick < 80) begin
				repeat ($urandom_range(1, 5)) put8(8'($urandom));
			end else if (pick >= 94) begin
				file_q.delete();
				repeat ($urandom_range(1, 12)) put8(8'($urandom));
			end
			send_file();
		end
		in_valid <= 1'b0;
		end_of_file <= 1'b0;

		do @(negedge clk); while (results_pending != 0);
		repeat (20) @(negedge clk);
		$display("Sent %0d files, %0d bytes: directed header cases, then random clean and damaged files.",
			files_sent, bytes_sent);
		$display("Compared %0d result beats; %0d mismatches.", results_checked, mismatch_count);
		if (mismatch_count == 0 && results_pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
